[rtl/core/fmr_pkg.sv]
// Shared constants and types for the framed message receiver.
// Used by the controller, the datapath and the top level; no dependencies.
package fmr_pkg;

	localparam int PAYLOAD_BYTES = 16;
	localparam int HDR_BYTES     = 4;
	localparam int SUM_BYTES     = 4;
	localparam int SYNC_SHIFT    = 24;
	localparam int BYTE_W        = 8;
	localparam int WORD_W        = 32;

	// payload index width and the shared byte counter width
	localparam int PL_IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int CNT_W    = (PL_IDX_W > 2) ? PL_IDX_W : 2;

	// frame_status codes
	localparam logic [1:0] FS_GOOD    = 2'd0;
	localparam logic [1:0] FS_HDR_ERR = 2'd1;
	localparam logic [1:0] FS_SUM_ERR = 2'd2;

	typedef struct packed {
		logic restart;
		logic cnt_inc;
		logic cnt_clr;
		logic hdr_shift;
		logic sum_add;
		logic store_wr;
		logic rsum_shift;
		logic emit_start;
		logic load_err;
	} fmr_cmd_t;

	typedef struct packed {
		logic sync_hit;
		logic cnt_hdr_end;
		logic cnt_pl_end;
		logic cnt_sum_end;
		logic frame_ok;
		logic out_free;
		logic emit_done;
	} fmr_sts_t;

endpackage

[rtl/core/framed_message_receiver.sv]
// Framed message receiver top level: controller plus datapath.
// Depends on fmr_pkg, fmr_ctrl and fmr_dpath.
//
// Each received byte is one input beat, accepted while the receiver is collecting
// a frame (header hunt, payload, checksum). After the fourth checksum byte the
// frame is checked in the check state. A good frame then streams its PAYLOAD_BYTES
// bytes out at one beat per cycle while m_tready stays high, from the payload
// store's registered read port; m_tvalid for the first beat rises after the check
// state, the emit flag, the read register and the output register. A bad frame
// gives a single error beat. Input is held off from the last checksum byte until
// the last result beat has entered the output register.
// The header word should be written only while no frame is in progress.
module framed_message_receiver
	import fmr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [WORD_W-1:0] cfg_wr_data,  // [31:0] expected frame header word
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,      // [7:0] rx_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,      // [7:0] payload_byte
	output logic [1:0]        m_tuser,      // [1:0] frame_status
	output logic              m_tlast       // last_of_frame
);

	fmr_cmd_t cmd;
	fmr_sts_t sts;

	fmr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fmr_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

[rtl/core/fmr_ctrl.sv]
// Frame receiver controller: hunt, payload, checksum, check, emit and error sequencing.
// Depends on fmr_pkg; drives the datapath through fmr_cmd_t.
module fmr_ctrl
	import fmr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  fmr_sts_t sts,
	output fmr_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_DATA,
		ST_SUM,
		ST_CHECK,
		ST_EMIT,
		ST_ERR
	} state_t;

	state_t state_q, state_nxt;
	logic   acc;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		s_tready  = (state_q == ST_HUNT) || (state_q == ST_DATA) || (state_q == ST_SUM);
		acc       = s_tvalid && s_tready;
		unique case (state_q)
			ST_HUNT: begin
				if (acc) begin
					if (sts.sync_hit) begin
						cmd.hdr_shift = 1'b1;
						cmd.sum_add   = 1'b1;
						if (sts.cnt_hdr_end) begin
							cmd.cnt_clr = 1'b1;
							state_nxt   = ST_DATA;
						end else begin
							cmd.cnt_inc = 1'b1;
						end
					end else begin
						cmd.restart = 1'b1;
					end
				end
			end
			ST_DATA: begin
				if (acc) begin
					cmd.store_wr = 1'b1;
					cmd.sum_add  = 1'b1;
					if (sts.cnt_pl_end) begin
						cmd.cnt_clr = 1'b1;
						state_nxt   = ST_SUM;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			ST_SUM: begin
				if (acc) begin
					cmd.rsum_shift = 1'b1;
					cmd.cnt_inc    = 1'b1;
					if (sts.cnt_sum_end)
						state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.frame_ok) begin
					cmd.emit_start = 1'b1;
					state_nxt      = ST_EMIT;
				end else begin
					state_nxt = ST_ERR;
				end
			end
			ST_ERR: begin
				if (sts.out_free) begin
					cmd.load_err = 1'b1;
					cmd.restart  = 1'b1;
					state_nxt    = ST_HUNT;
				end
			end
			ST_EMIT: begin
				if (sts.emit_done) begin
					cmd.restart = 1'b1;
					state_nxt   = ST_HUNT;
				end
			end
			default: begin
				cmd.restart = 1'b1;
				state_nxt   = ST_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_nxt;
		end
	end

	// no input beat is taken while a verdict or a payload burst is pending
	a_no_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT || state_q == ST_ERR || state_q == ST_CHECK) |-> !acc)
		else $error("input beat accepted while frame result pending");

	// the check state is always followed by emit or error on the next cycle
	a_check_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |=> (state_q == ST_EMIT || state_q == ST_ERR))
		else $error("check state did not resolve");

	// emit is entered only with a good verdict
	a_emit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && state_nxt == ST_EMIT) |-> sts.frame_ok)
		else $error("emit started on a failed frame");

endmodule

[rtl/core/fmr_dpath.sv]
// Frame receiver datapath: magic register, byte counter, header and sum registers,
// payload store and the output beat register. Depends on fmr_pkg.
module fmr_dpath
	import fmr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [WORD_W-1:0] cfg_wr_data,
	input  logic [BYTE_W-1:0] s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,
	output logic [1:0]        m_tuser,
	output logic              m_tlast,
	input  fmr_cmd_t          cmd,
	output fmr_sts_t          sts
);

	logic [WORD_W-1:0]   magic_q;
	logic [WORD_W-1:0]   hdr_q;
	logic [WORD_W-1:0]   sum_q;
	logic [WORD_W-1:0]   rsum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [BYTE_W-1:0]   store_q [PAYLOAD_BYTES];

	logic                emit_q;
	logic [PL_IDX_W-1:0] ecnt_q;
	logic                rd_valid_s1;
	logic [BYTE_W-1:0]   rd_data_s1;
	logic                rd_last_s1;

	logic                out_free;
	logic                load_out;
	logic                rd_en;
	logic                ecnt_last;
	logic                hdr_ok;

	assign out_free  = !m_tvalid || m_tready;
	assign load_out  = rd_valid_s1 && out_free;
	assign rd_en     = emit_q && (!rd_valid_s1 || load_out);
	assign ecnt_last = (ecnt_q == PL_IDX_W'(PAYLOAD_BYTES - 1));
	assign hdr_ok    = (hdr_q == magic_q);

	always_comb begin
		sts             = '0;
		sts.sync_hit    = (s_tdata == magic_q[SYNC_SHIFT +: BYTE_W]);
		sts.cnt_hdr_end = (cnt_q == CNT_W'(HDR_BYTES - 1));
		sts.cnt_pl_end  = (cnt_q == CNT_W'(PAYLOAD_BYTES - 1));
		sts.cnt_sum_end = (cnt_q == CNT_W'(SUM_BYTES - 1));
		sts.frame_ok    = hdr_ok && (rsum_q == sum_q);
		sts.out_free    = out_free;
		sts.emit_done   = load_out && rd_last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= '0;
			hdr_q   <= '0;
			sum_q   <= '0;
			rsum_q  <= '0;
			cnt_q   <= '0;
		end else begin
			if (cfg_wr_en)
				magic_q <= cfg_wr_data;
			if (cmd.restart) begin
				hdr_q  <= '0;
				sum_q  <= '0;
				rsum_q <= '0;
				cnt_q  <= '0;
			end else begin
				// little-endian assembly: first byte ends up lowest after four shifts
				if (cmd.hdr_shift)
					hdr_q <= {s_tdata, hdr_q[WORD_W-1:BYTE_W]};
				if (cmd.rsum_shift)
					rsum_q <= {s_tdata, rsum_q[WORD_W-1:BYTE_W]};
				if (cmd.sum_add)
					sum_q <= sum_q + {{(WORD_W-BYTE_W){1'b0}}, s_tdata};
				if (cmd.cnt_clr)
					cnt_q <= '0;
				else if (cmd.cnt_inc)
					cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// payload store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.store_wr)
			store_q[cnt_q[PL_IDX_W-1:0]] <= s_tdata;
		if (rd_en)
			rd_data_s1 <= store_q[ecnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q      <= 1'b0;
			ecnt_q      <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
		end else begin
			if (cmd.emit_start) begin
				emit_q <= 1'b1;
				ecnt_q <= '0;
			end else if (rd_en) begin
				ecnt_q <= ecnt_q + PL_IDX_W'(1);
				if (ecnt_last)
					emit_q <= 1'b0;
			end
			if (rd_en) begin
				rd_valid_s1 <= 1'b1;
				rd_last_s1  <= ecnt_last;
			end else if (load_out) begin
				rd_valid_s1 <= 1'b0;
			end
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load_out || cmd.load_err) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata <= rd_data_s1;
			m_tuser <= FS_GOOD;
			m_tlast <= rd_last_s1;
		end else if (cmd.load_err) begin
			m_tdata <= '0;
			m_tuser <= hdr_ok ? FS_SUM_ERR : FS_HDR_ERR;
			m_tlast <= 1'b1;
		end
	end

	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_err |-> (!rd_valid_s1 && !emit_q))
		else $error("error beat collides with payload burst");

	a_emit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_start |-> (!emit_q && !rd_valid_s1))
		else $error("burst started while previous one active");

	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_valid_s1 && !rd_last_s1) |-> emit_q)
		else $error("burst ended before last payload byte");

	a_store_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_wr |-> (cnt_q <= CNT_W'(PAYLOAD_BYTES - 1)))
		else $error("payload write beyond store");

endmodule
